>>> sv/periodic_task_service_timer_defines.svh
// Assertion macros for the periodic task service timer.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef PERIODIC_TASK_SERVICE_TIMER_DEFINES_SVH
`define PERIODIC_TASK_SERVICE_TIMER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pst_pkg.sv
// Shared types and constants for the periodic task service timer.
// Used by the channel interfaces, the evaluation logic and the top level.
package pst_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_FORCE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_PERIOD      = 2'd0,
    REG_ITER_LIMIT  = 2'd1,
    REG_OVERDUE_THR = 2'd2
  } cfg_reg_e;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned IterW   = 16;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned BehindW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic signed [IterW-1:0] IterForever = -16'sd1;

  // Task state carried from one item to the next.
  typedef struct packed {
    logic                     enabled;
    logic                     force_pending;
    logic [TimeW-1:0]         scheduled_time;
    logic signed [IterW-1:0]  remaining;
    logic [BehindW-1:0]       behind_count;
  } state_t;

  // Configuration seen by the evaluation logic.
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [ThrW-1:0]    overdue_threshold;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                    serviced;
    logic                    overscheduled;
    logic                    finished;
    logic signed [IterW-1:0] iterations_left;
  } result_t;

endpackage

>>> sv/pst_channels.sv
// Valid/ready channel interfaces for the periodic task service timer.
// Depends on pst_pkg for field widths.
interface pst_item_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [pst_pkg::TimeW-1:0]   now;

  modport source (output valid, kind, now, input ready);
  modport sink   (input valid, kind, now, output ready);
endinterface

interface pst_result_if;
  logic                               valid;
  logic                               ready;
  logic                               serviced;
  logic                               overscheduled;
  logic                               finished;
  logic signed [pst_pkg::IterW-1:0]   iterations_left;

  modport source (output valid, serviced, overscheduled, finished, iterations_left,
                  input ready);
  modport sink   (input valid, serviced, overscheduled, finished, iterations_left,
                  output ready);
endinterface

interface pst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pst_pkg::CfgIdxW-1:0]   index;
  logic [pst_pkg::CfgW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/pst_eval.sv
// Single-pass evaluation of one item against the task state.
// Depends on pst_pkg for the state, configuration and result types.
module pst_eval (
  input  logic [1:0]                 kind_i,
  input  logic [pst_pkg::TimeW-1:0]  now_i,
  input  pst_pkg::cfg_t              cfg_i,
  input  pst_pkg::state_t            state_i,
  output pst_pkg::state_t            state_o,
  output pst_pkg::result_t           result_o
);

  logic                          period_zero;
  logic [pst_pkg::TimeW-1:0]     period_ext;
  logic                          time_ok;
  logic                          iter_ok;
  logic                          forced;
  logic [pst_pkg::TimeW-1:0]     sched_new;
  logic                          late;
  logic [pst_pkg::BehindW-1:0]   behind_inc;
  logic signed [pst_pkg::IterW-1:0] rem_dec;

  assign period_zero = (cfg_i.period == '0);
  assign period_ext  = {{(pst_pkg::TimeW - pst_pkg::PeriodW){1'b0}}, cfg_i.period};
  assign time_ok     = period_zero || ((now_i - state_i.scheduled_time) >= period_ext);
  assign iter_ok     = (state_i.remaining == pst_pkg::IterForever) ||
                       (state_i.remaining > 16'sd0);
  assign forced      = state_i.force_pending;

  // A normal service advances the schedule; a forced one keeps it.
  always_comb begin
    if (forced) begin
      sched_new = state_i.scheduled_time;
    end else if (period_zero) begin
      sched_new = now_i;
    end else begin
      sched_new = state_i.scheduled_time + period_ext;
    end
  end

  // The late check looks at the schedule after the update.
  assign late       = (now_i - sched_new) >= period_ext;
  assign behind_inc = state_i.behind_count + 16'd1;
  assign rem_dec    = state_i.remaining - 16'sd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (pst_pkg::kind_e'(kind_i))
      pst_pkg::KIND_ENABLE:  state_o.enabled       = 1'b1;
      pst_pkg::KIND_DISABLE: state_o.enabled       = 1'b0;
      pst_pkg::KIND_FORCE:   state_o.force_pending = 1'b1;
      pst_pkg::KIND_TICK: begin
        if (state_i.enabled && (forced || (time_ok && iter_ok))) begin
          result_o.serviced      = 1'b1;
          state_o.scheduled_time = sched_new;
          state_o.force_pending  = 1'b0;
          if ((cfg_i.overdue_threshold != '0) && late) begin
            if (behind_inc >= {1'b0, cfg_i.overdue_threshold}) begin
              result_o.overscheduled = 1'b1;
              state_o.behind_count   = '0;
            end else begin
              state_o.behind_count   = behind_inc;
            end
          end else begin
            state_o.behind_count = '0;
          end
          if (!forced && (state_i.remaining > 16'sd0)) begin
            state_o.remaining = rem_dec;
            if (rem_dec == 16'sd0) begin
              result_o.finished = 1'b1;
              state_o.enabled   = 1'b0;
            end
          end
        end
      end
      default: state_o = state_i;
    endcase
    result_o.iterations_left = state_o.remaining;
  end

endmodule

>>> sv/periodic_task_service_timer.sv
// Periodic task service timer: an accepted item passes the input register, then the result
// register; throughput is one item per cycle, set by the single-pass evaluation between
// the two registers, stalling only when the result is held.
// Reset clears the task state (disabled, no force pending, schedule zero, iterations
// forever, behind count zero) and the registers (period zero, threshold zero).
// Depends on pst_pkg, pst_channels, pst_eval and periodic_task_service_timer_defines.svh.
`include "periodic_task_service_timer_defines.svh"

module periodic_task_service_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  pst_cfg_if.sink            cfg_i,
  pst_item_if.sink           item_i,
  pst_result_if.source       result_o
);

  // Input register stage holding one accepted item.
  logic                         in_valid_q, in_valid_d;
  logic [1:0]                   in_kind_q;
  logic [pst_pkg::TimeW-1:0]    in_now_q;

  // Result register stage.
  logic                         out_valid_q, out_valid_d;
  pst_pkg::result_t             out_q;

  // Task state and configuration.
  pst_pkg::state_t              state_q, state_d;
  pst_pkg::cfg_t                cfg_q;

  pst_pkg::state_t              eval_state;
  pst_pkg::result_t             eval_result;

  logic                         advance;
  logic                         in_fire;
  logic                         load;
  logic                         cfg_fire;

  // The stage moves forward whenever the result register is empty or being drained.
  // The input register takes a new item when it is empty or moving forward, so the
  // input stalls only while both registers hold items and the result is still waiting.
  assign advance       = !out_valid_q || result_o.ready;
  assign item_i.ready  = !in_valid_q || advance;
  assign in_fire       = item_i.valid && item_i.ready;
  assign load          = in_valid_q && advance;

  // Configuration is taken at any time; the user must write it only while the block is idle, which it does not enforce.
  assign cfg_i.ready   = 1'b1;
  assign cfg_fire      = cfg_i.valid;

  assign in_valid_d  = in_fire ? 1'b1 : (load ? 1'b0 : in_valid_q);
  assign out_valid_d = load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  pst_eval u_eval (
    .kind_i   (in_kind_q),
    .now_i    (in_now_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (eval_state),
    .result_o (eval_result)
  );

  // Writing the iteration limit reloads the remaining count directly.
  always_comb begin
    state_d = state_q;
    if (load) begin
      state_d = eval_state;
    end
    if (cfg_fire && (pst_pkg::cfg_reg_e'(cfg_i.index) == pst_pkg::REG_ITER_LIMIT)) begin
      state_d.remaining = $signed(cfg_i.data[pst_pkg::IterW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{enabled: 1'b0, force_pending: 1'b0, scheduled_time: '0,
                       remaining: pst_pkg::IterForever, behind_count: '0};
      cfg_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      if (cfg_fire) begin
        unique case (pst_pkg::cfg_reg_e'(cfg_i.index))
          pst_pkg::REG_PERIOD:      cfg_q.period <= cfg_i.data[pst_pkg::PeriodW-1:0];
          pst_pkg::REG_OVERDUE_THR: cfg_q.overdue_threshold <= cfg_i.data[pst_pkg::ThrW-1:0];
          pst_pkg::REG_ITER_LIMIT:  cfg_q <= cfg_q;
          default:                  cfg_q <= cfg_q;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_kind_q <= item_i.kind;
      in_now_q  <= item_i.now;
    end
    if (load) begin
      out_q <= eval_result;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.serviced        = out_q.serviced;
  assign result_o.overscheduled   = out_q.overscheduled;
  assign result_o.finished        = out_q.finished;
  assign result_o.iterations_left = out_q.iterations_left;

  // A finishing service leaves the task disabled.
  `PST_ASSERT_NEXT(a_finish_disables, load && eval_result.finished, !state_q.enabled,
                   "finished result did not disable the task")
  // Only ticks can produce a service.
  `PST_ASSERT_NEXT(a_service_only_on_tick,
                   load && (pst_pkg::kind_e'(in_kind_q) != pst_pkg::KIND_TICK),
                   !out_q.serviced, "non-tick item reported a service")
  // The remaining count moves only with an evaluated item or a limit write.
  `PST_ASSERT_NEXT(a_remaining_stable, !load && !cfg_fire, $stable(state_q.remaining),
                   "remaining count changed without cause")
  // An accepted item always lands in the input register.
  `PST_ASSERT_NEXT(a_input_captured, in_fire, in_valid_q,
                   "accepted item was not captured")

endmodule
